// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths and defaults for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned CoordBitsDef = 16;

  localparam int unsigned FieldBits  = 16;
  localparam int unsigned ThreshBits = 17;
  localparam int unsigned IdxBits    = 6;
  localparam int unsigned InBits     = 5 * FieldBits;
  localparam int unsigned OutBits    = 8;

  localparam logic [ThreshBits-1:0] ThreshReset = 17'd32768;

endpackage

// ===== design/gbn_iou.sv =====
// ----------------------------------------------------------------------------
// gbn_iou
// Five-stage pipelined overlap test: flags inter * 65536 > thresh * union.
// ----------------------------------------------------------------------------
module gbn_iou #(
  parameter int unsigned COORD_BITS = gbn_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [4*COORD_BITS-1:0]           box_a_i,
  input  logic [4*COORD_BITS-1:0]           box_b_i,
  input  logic [gbn_pkg::ThreshBits-1:0]    thresh_i,
  output logic                              done_o,
  output logic                              supp_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EB = CB + 1;           // edge and extent width
  localparam int unsigned AB = 2 * CB;           // area width
  localparam int unsigned IB = 2 * EB;           // intersection product width
  localparam int unsigned UB = 2 * CB + 1;       // union width
  localparam int unsigned LB = CB + 1;           // low slice of union
  localparam int unsigned HB = UB - LB;          // high slice of union
  localparam int unsigned TB = gbn_pkg::ThreshBits;
  localparam int unsigned RB = UB + TB;          // compare width

  logic [4:0] vld_q;

  logic [CB-1:0] la, ta, wa, ha, lb, tb, wb, hb;
  logic [EB-1:0] ra, ba, rb, bb, rmin, lmax, bmin, tmax;

  logic [EB-1:0] iw_q, ih_q;
  logic [CB-1:0] wa_q, ha_q, wb_q, hb_q;
  logic [IB-1:0] inter2_q;
  logic [AB-1:0] area_a_q, area_b_q;
  logic [IB-1:0] inter3_q;
  logic [UB-1:0] uni_q;
  logic [IB-1:0] inter4_q;
  logic [LB+TB-1:0] plo_q;
  logic [HB+TB-1:0] phi_q;
  logic supp_q;
  logic [RB-1:0] rhs, lhs;

  // unpack and form the overlap window
  always_comb begin
    la = box_a_i[0*CB +: CB];
    ta = box_a_i[1*CB +: CB];
    wa = box_a_i[2*CB +: CB];
    ha = box_a_i[3*CB +: CB];
    lb = box_b_i[0*CB +: CB];
    tb = box_b_i[1*CB +: CB];
    wb = box_b_i[2*CB +: CB];
    hb = box_b_i[3*CB +: CB];
    ra = EB'(la) + EB'(wa);
    ba = EB'(ta) + EB'(ha);
    rb = EB'(lb) + EB'(wb);
    bb = EB'(tb) + EB'(hb);
    rmin = (ra < rb) ? ra : rb;
    bmin = (ba < bb) ? ba : bb;
    lmax = (la > lb) ? EB'(la) : EB'(lb);
    tmax = (ta > tb) ? EB'(ta) : EB'(tb);
  end

  // track the item through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    iw_q <= (rmin > lmax) ? rmin - lmax : '0;
    ih_q <= (bmin > tmax) ? bmin - tmax : '0;
    wa_q <= wa;
    ha_q <= ha;
    wb_q <= wb;
    hb_q <= hb;

    inter2_q <= IB'(iw_q) * IB'(ih_q);
    area_a_q <= AB'(wa_q) * AB'(ha_q);
    area_b_q <= AB'(wb_q) * AB'(hb_q);

    uni_q    <= UB'(UB'(area_a_q) + UB'(area_b_q) - UB'(inter2_q));
    inter3_q <= inter2_q;

    plo_q    <= (LB+TB)'(uni_q[LB-1:0]) * (LB+TB)'(thresh_i);
    phi_q    <= (HB+TB)'(uni_q[UB-1:LB]) * (HB+TB)'(thresh_i);
    inter4_q <= inter3_q;

    supp_q <= lhs > rhs;
  end

  // recombine the split product and compare
  always_comb begin
    rhs = (RB'(phi_q) << LB) + RB'(plo_q);
    lhs = RB'(inter4_q) << 16;
  end

  assign done_o = vld_q[4];
  assign supp_o = supp_q;

endmodule

// ===== design/greedy_box_nms.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over one set of boxes, memory based.
// ----------------------------------------------------------------------------
// Load: one box beat per cycle; a set closes on the beat with tlast.
// Ranking: rank by counting over the score memory port.
// Suppression: per box pair, rank read, box read, start, then the 5-stage IoU.
// Emit: rank read, output load, then a wait on sink stall; no beat is taken until done.
// Reset clears control state and sets the threshold to 0.5; memories untouched.
module greedy_box_nms #(
  parameter int unsigned MAX_BOXES  = gbn_pkg::MaxBoxesDef,
  parameter int unsigned COORD_BITS = gbn_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // box_left, box_top, box_width, box_height, box_score
  input  logic [gbn_pkg::InBits-1:0]        s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,   // last_box
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // box_index, keep, overflow
  output logic [gbn_pkg::OutBits-1:0]       m_axis_tdata_o,
  output logic                              m_axis_tlast_o,   // last_result
  input  logic                              cfg_we_i,
  input  logic [gbn_pkg::ThreshBits-1:0]    cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned BW = 4 * COORD_BITS;
  localparam int unsigned FB = gbn_pkg::FieldBits;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_SI   = 4'd1;
  localparam logic [3:0] S_SIW  = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SCMP = 4'd4;
  localparam logic [3:0] S_SWR  = 4'd5;
  localparam logic [3:0] S_NI   = 4'd6;
  localparam logic [3:0] S_NIA  = 4'd7;
  localparam logic [3:0] S_NIB  = 4'd8;
  localparam logic [3:0] S_NJ   = 4'd9;
  localparam logic [3:0] S_NJA  = 4'd10;
  localparam logic [3:0] S_NJB  = 4'd11;
  localparam logic [3:0] S_NW   = 4'd12;
  localparam logic [3:0] S_ERD  = 4'd13;
  localparam logic [3:0] S_EOUT = 4'd14;
  localparam logic [3:0] S_EW   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [MAX_BOXES-1:0] keep_q, keep_d;
  logic [FB-1:0] score_i_q, score_i_d;
  logic [BW-1:0] box_a_q, box_a_d;
  logic [gbn_pkg::ThreshBits-1:0] thresh_q;
  logic ovalid_q, ovalid_d;
  logic [IW-1:0] oidx_q, oidx_d;
  logic okeep_q, okeep_d, oovf_q, oovf_d, olast_q, olast_d;

  // memories
  logic [BW-1:0] box_mem [MAX_BOXES];
  logic [FB-1:0] score_mem [MAX_BOXES];
  logic [IW-1:0] rank_mem [MAX_BOXES];
  logic [BW-1:0] box_rd_q;
  logic [FB-1:0] score_rd_q;
  logic [IW-1:0] rank_rd_q;
  logic [IW-1:0] box_raddr, score_raddr, rank_raddr;

  logic in_beat, out_beat, iou_start, iou_done, iou_supp;
  logic [IW-1:0] last_idx, wr_idx;
  logic [BW-1:0] in_box;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = ovalid_q && m_axis_tready_i;
  assign last_idx = IW'(count_q - CW'(1));
  assign wr_idx   = IW'(count_q);

  // pack the coordinates at the configured width
  assign in_box = {COORD_BITS'(s_axis_tdata_i[3*FB +: FB]),
                   COORD_BITS'(s_axis_tdata_i[2*FB +: FB]),
                   COORD_BITS'(s_axis_tdata_i[1*FB +: FB]),
                   COORD_BITS'(s_axis_tdata_i[0*FB +: FB])};

  // read addresses per phase
  always_comb begin
    score_raddr = (state_q == S_SI) ? i_q : j_q;
    rank_raddr  = (state_q == S_NI) ? i_q : ((state_q == S_ERD) ? i_q : j_q);
    box_raddr   = rank_rd_q;
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (in_beat && (count_q < CW'(MAX_BOXES))) begin
      box_mem[wr_idx]   <= in_box;
      score_mem[wr_idx] <= s_axis_tdata_i[4*FB +: FB];
    end
    if (state_q == S_SWR) begin
      rank_mem[rank_q] <= i_q;
    end
    box_rd_q   <= box_mem[box_raddr];
    score_rd_q <= score_mem[score_raddr];
    rank_rd_q  <= rank_mem[rank_raddr];
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= gbn_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  gbn_iou #(
    .COORD_BITS (COORD_BITS)
  ) u_iou (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (iou_start),
    .box_a_i  (box_a_q),
    .box_b_i  (box_rd_q),
    .thresh_i (thresh_q),
    .done_o   (iou_done),
    .supp_o   (iou_supp)
  );

  assign iou_start = (state_q == S_NJB);

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    rank_d    = rank_q;
    keep_d    = keep_q;
    score_i_d = score_i_q;
    box_a_d   = box_a_q;
    ovalid_d  = ovalid_q;
    oidx_d    = oidx_q;
    okeep_d   = okeep_q;
    oovf_d    = oovf_q;
    olast_d   = olast_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_beat) begin
          if (count_q < CW'(MAX_BOXES)) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            i_d     = '0;
            state_d = S_SI;
          end
        end
      end
      S_SI: state_d = S_SIW;
      S_SIW: begin
        score_i_d = score_rd_q;
        j_d       = '0;
        rank_d    = '0;
        state_d   = S_SRD;
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        // count boxes ranked ahead of box i
        if ((score_rd_q > score_i_q) || ((score_rd_q == score_i_q) && (j_q < i_q))) begin
          rank_d = rank_q + IW'(1);
        end
        if (j_q == last_idx) begin
          state_d = S_SWR;
        end else begin
          j_d     = j_q + IW'(1);
          state_d = S_SRD;
        end
      end
      S_SWR: begin
        if (i_q == last_idx) begin
          i_d     = '0;
          state_d = S_NI;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = S_SI;
        end
      end
      S_NI: begin
        if (i_q == last_idx) begin
          i_d     = '0;
          state_d = S_ERD;
        end else if (!keep_q[i_q]) begin
          i_d = i_q + IW'(1);
        end else begin
          state_d = S_NIA;
        end
      end
      S_NIA: state_d = S_NIB;
      S_NIB: begin
        box_a_d = box_rd_q;
        j_d     = i_q + IW'(1);
        state_d = S_NJ;
      end
      S_NJ:  state_d = S_NJA;
      S_NJA: state_d = S_NJB;
      S_NJB: state_d = S_NW;
      S_NW: begin
        if (iou_done) begin
          if (iou_supp) begin
            keep_d[j_q] = 1'b0;
          end
          if (j_q == last_idx) begin
            i_d     = i_q + IW'(1);
            state_d = S_NI;
          end else begin
            j_d     = j_q + IW'(1);
            state_d = S_NJ;
          end
        end
      end
      S_ERD: state_d = S_EOUT;
      S_EOUT: begin
        ovalid_d = 1'b1;
        oidx_d   = rank_rd_q;
        okeep_d  = keep_q[i_q];
        oovf_d   = ovf_q;
        olast_d  = (i_q == last_idx);
        state_d  = S_EW;
      end
      S_EW: begin
        if (out_beat) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            keep_d  = '1;
            state_d = S_LOAD;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      rank_q   <= '0;
      keep_q   <= '1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      rank_q   <= rank_d;
      keep_q   <= keep_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    score_i_q <= score_i_d;
    box_a_q   <= box_a_d;
    oidx_q    <= oidx_d;
    okeep_q   <= okeep_d;
    oovf_q    <= oovf_d;
    olast_q   <= olast_d;
  end

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {oovf_q, okeep_q, gbn_pkg::IdxBits'(oidx_q)};
  assign m_axis_tlast_o  = olast_q;

endmodule

// ===== design/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks for greedy_box_nms, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           s_axis_tlast_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [gbn_pkg::OutBits-1:0]    m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // never load and emit at once
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  // closing beat stops the input side
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input still ready after set close");

  // final result returns the block to loading
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=>
      s_axis_tready_o && !m_axis_tvalid_o)
    else $error("block not reopened after last result");

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
